FILE: hw/rtl/bdq_pkg.sv
package bdq_pkg;

   // field widths of the request and response beats
   localparam int WORD_W = 32;
   localparam int OP_W   = 3;
   localparam int POS_W  = 6;
   localparam int STAT_W = 2;
   localparam int CNT_W  = 7;

   typedef logic signed [WORD_W-1:0] bdq_word_type;

   // request operation codes
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd1;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OP_W-1:0] OP_READ       = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

   // response status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]  operation;
      bdq_word_type     value;
      logic [POS_W-1:0] position;
   } bdq_req_type;

   typedef struct packed {
      bdq_word_type      data;
      logic [STAT_W-1:0] status;
      logic [CNT_W-1:0]  count;
   } bdq_rsp_type;

   // command broadcast to every cell of the row
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_PUSH_FRONT,
      CMD_POP_FRONT,
      CMD_PUSH_BACK,
      CMD_SNAP
   } bdq_cmd_type;

   typedef struct packed {
      bdq_cmd_type  cmd;
      bdq_word_type value;
   } bdq_cell_ctrl_type;

endpackage

FILE: hw/rtl/bdq_cell.sv
module bdq_cell (
   input  logic                       clock,
   input  bdq_pkg::bdq_cell_ctrl_type ctrl,
   input  logic                       sel_back,
   input  bdq_pkg::bdq_word_type      prev_elem,
   input  bdq_pkg::bdq_word_type      next_elem,
   input  bdq_pkg::bdq_word_type      next_tap,
   output bdq_pkg::bdq_word_type      elem,
   output bdq_pkg::bdq_word_type      tap
);
   import bdq_pkg::*;

   bdq_word_type elem_ff;
   bdq_word_type elem_in;
   bdq_word_type tap_ff;
   bdq_word_type tap_in;

   // element slot: shift toward the back, toward the front, or take a back push
   always_comb begin
      elem_in = elem_ff;
      case (ctrl.cmd)
         CMD_PUSH_FRONT: elem_in = prev_elem;
         CMD_POP_FRONT:  elem_in = next_elem;
         CMD_PUSH_BACK: begin
            if (sel_back) begin
               elem_in = ctrl.value;
            end
         end
         default: elem_in = elem_ff;
      endcase
   end

   // tap line: snapshot of the elements, walking one cell toward the front
   assign tap_in = (ctrl.cmd == CMD_SNAP) ? elem_ff : next_tap;

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
      tap_ff  <= tap_in;
   end

   assign elem = elem_ff;
   assign tap  = tap_ff;

endmodule

FILE: hw/rtl/bounded_deque_engine_unit.sv
// Bounded double-ended queue of signed 32-bit words, held in a row of DEPTH
// cells with the front element always in cell 0. Push front, pop front, push
// back, clear and refused requests are answered directly: a new request can
// be accepted every cycle while no response is held by rsp_stall, and its
// response appears in the output register on the next cycle. Pop back and
// read fetch the word at index k from the front (count - 1 for pop back,
// position for read): the row is copied into a tap line that moves one cell
// toward cell 0 per cycle, and the word is taken from cell 0 once it
// arrives. req_stall is high while such a walk is running and while a
// finished response is held by rsp_stall. The element store has no reset;
// only slots written by a push are ever returned.
module bounded_deque_engine_unit #(
   parameter int DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bdq_pkg::bdq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bdq_pkg::bdq_rsp_type rsp_data
);
   import bdq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_WALK = 2'b10
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic [AW-1:0]     walk_ff;
   logic [AW-1:0]     walk_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   bdq_rsp_type       rsp_ff;
   bdq_rsp_type       rsp_in;
   bdq_cell_ctrl_type cell_ctrl;
   logic              accept;
   logic              full;
   logic              empty;
   logic [DEPTH-1:0]  sel_back;
   bdq_word_type      elem_w [DEPTH];
   bdq_word_type      tap_w  [DEPTH];

   // handshake
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);

   // row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      bdq_word_type prev_w;
      bdq_word_type next_w;
      bdq_word_type next_tap_w;

      assign sel_back[i] = (count_ff == CW'(i));

      if (i == 0) begin : g_head
         assign prev_w = cell_ctrl.value;
      end else begin : g_body
         assign prev_w = elem_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_w     = '0;
         assign next_tap_w = '0;
      end else begin : g_link
         assign next_w     = elem_w[i+1];
         assign next_tap_w = tap_w[i+1];
      end

      bdq_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .sel_back  (sel_back[i]),
         .prev_elem (prev_w),
         .next_elem (next_w),
         .next_tap  (next_tap_w),
         .elem      (elem_w[i]),
         .tap       (tap_w[i])
      );
   end

   // request decode and walk sequencing
   always_comb begin
      cell_ctrl.cmd   = CMD_HOLD;
      cell_ctrl.value = req_data.value;
      count_in        = count_ff;
      state_in        = state_ff;
      walk_in         = walk_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_in          = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in.data   = '0;
               rsp_in.status = STAT_OK;
               rsp_valid_in  = 1'b1;
               unique case (req_data.operation)
                  OP_PUSH_BACK: begin
                     if (full) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        cell_ctrl.cmd = CMD_PUSH_BACK;
                        count_in      = count_ff + CW'(1);
                     end
                  end
                  OP_POP_BACK: begin
                     if (empty) begin
                        rsp_in.status = STAT_EMPTY;
                     end else begin
                        cell_ctrl.cmd = CMD_SNAP;
                        count_in      = count_ff - CW'(1);
                        walk_in       = AW'(count_ff - CW'(1));
                        state_in      = S_WALK;
                        rsp_valid_in  = 1'b0;
                     end
                  end
                  OP_PUSH_FRONT: begin
                     if (full) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        cell_ctrl.cmd = CMD_PUSH_FRONT;
                        count_in      = count_ff + CW'(1);
                     end
                  end
                  OP_POP_FRONT: begin
                     if (empty) begin
                        rsp_in.status = STAT_EMPTY;
                     end else begin
                        cell_ctrl.cmd = CMD_POP_FRONT;
                        rsp_in.data   = elem_w[0];
                        count_in      = count_ff - CW'(1);
                     end
                  end
                  OP_READ: begin
                     if (PW'(req_data.position) >= PW'(count_ff)) begin
                        rsp_in.status = STAT_RANGE;
                     end else begin
                        cell_ctrl.cmd = CMD_SNAP;
                        walk_in       = AW'(req_data.position);
                        state_in      = S_WALK;
                        rsp_valid_in  = 1'b0;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
               rsp_in.count = CNT_W'(count_in);
            end
         end
         S_WALK: begin
            if (walk_ff == '0) begin
               rsp_in.data  = tap_w[0];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               walk_in = walk_ff - AW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response beat register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // element count stays within the row
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count beyond depth");

   // no request is taken during a walk
   a_walk_blocks : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> req_stall)
      else $error("request taken during walk");

   // the response register is free for the whole walk
   a_walk_slot_free : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> !rsp_valid_ff)
      else $error("response pending during walk");

   // a refused push leaves the count alone
   a_full_push : assert property (@(posedge clock) disable iff (reset)
      (accept && full && (req_data.operation == OP_PUSH_BACK ||
                          req_data.operation == OP_PUSH_FRONT))
      |=> (count_ff == $past(count_ff)))
      else $error("count changed on refused push");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import bdq_pkg::*;

   localparam int DEQUE_DEPTH  = 64;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 80;

   // operation codes that the block treats as no operation
   localparam logic [OP_W-1:0] OP_NOP_SIX   = 3'd6;
   localparam logic [OP_W-1:0] OP_NOP_SEVEN = 3'd7;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   bdq_req_type  req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   bdq_rsp_type  rsp_data;

   // predicted deque contents
   bdq_word_type     deque_slots [DEQUE_DEPTH];
   logic [POS_W-1:0] deque_head = '0;
   logic [CNT_W-1:0] deque_len  = '0;

   bdq_rsp_type pending_rsp [$];
   int          error_count = 0;
   int          cycle_count = 0;
   logic        calm_phase  = 1'b0;
   int          stall_left  = 0;

   bounded_deque_engine_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // deque behaviour for one request, updating the predicted state
   function automatic bdq_rsp_type deque_apply(input bdq_req_type rq);
      bdq_rsp_type      rs;
      logic [POS_W-1:0] idx;
      rs        = '0;
      rs.status = STAT_OK;
      case (rq.operation)
         OP_PUSH_BACK: begin
            if (deque_len == DEQUE_DEPTH) begin
               rs.status = STAT_FULL;
            end else begin
               idx              = deque_head + deque_len[POS_W-1:0];
               deque_slots[idx] = rq.value;
               deque_len        = deque_len + CNT_W'(1);
            end
         end
         OP_POP_BACK: begin
            if (deque_len == 0) begin
               rs.status = STAT_EMPTY;
            end else begin
               deque_len = deque_len - CNT_W'(1);
               idx       = deque_head + deque_len[POS_W-1:0];
               rs.data   = deque_slots[idx];
            end
         end
         OP_PUSH_FRONT: begin
            if (deque_len == DEQUE_DEPTH) begin
               rs.status = STAT_FULL;
            end else begin
               deque_head              = deque_head - POS_W'(1);
               deque_slots[deque_head] = rq.value;
               deque_len               = deque_len + CNT_W'(1);
            end
         end
         OP_POP_FRONT: begin
            if (deque_len == 0) begin
               rs.status = STAT_EMPTY;
            end else begin
               rs.data    = deque_slots[deque_head];
               deque_head = deque_head + POS_W'(1);
               deque_len  = deque_len - CNT_W'(1);
            end
         end
         OP_READ: begin
            if ({1'b0, rq.position} >= deque_len) begin
               rs.status = STAT_RANGE;
            end else begin
               idx     = deque_head + rq.position;
               rs.data = deque_slots[idx];
            end
         end
         OP_CLEAR: begin
            deque_len  = '0;
            deque_head = '0;
         end
         default: begin
         end
      endcase
      rs.count = deque_len;
      return rs;
   endfunction

   function automatic bdq_req_type make_req(input logic [OP_W-1:0] op,
                                            input bdq_word_type value,
                                            input logic [POS_W-1:0] pos);
      bdq_req_type rq;
      rq.operation = op;
      rq.value     = value;
      rq.position  = pos;
      return rq;
   endfunction

   // mostly random words, sometimes the extremes
   function automatic bdq_word_type rand_word();
      case ($urandom_range(0, 15))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // drive one beat and hold it until accepted, then predict its response
   task automatic send_req(input bdq_req_type rq);
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(deque_apply(rq));
   endtask

   task automatic hold_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // random gap between beats, none in the calm tail
   task automatic maybe_gap();
      if (!calm_phase && $urandom_range(0, 7) == 0)
         hold_sender($urandom_range(1, 13));
   endtask

   task automatic send_gapped(input bdq_req_type rq);
      send_req(rq);
      maybe_gap();
   endtask

   // random beats with a chosen share of pushes
   task automatic send_random(input int n, input int push_pct);
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] pos;
      int               pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < push_pct)
            op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         else if (pick < push_pct + 20)
            op = OP_READ;
         else if (pick < 97)
            op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
         else if (pick < 98)
            op = OP_CLEAR;
         else
            op = $urandom_range(0, 1) ? OP_NOP_SIX : OP_NOP_SEVEN;
         if (deque_len != 0 && $urandom_range(0, 4) != 0)
            pos = POS_W'($urandom_range(0, deque_len - 1));
         else
            pos = POS_W'($urandom_range(0, 63));
         send_gapped(make_req(op, rand_word(), pos));
      end
   endtask

   task automatic wait_for_drain();
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // corner cases on an empty and a short deque
   task automatic test_edge_cases();
      send_gapped(make_req(OP_POP_BACK, 32'sd5, 6'd0));
      send_gapped(make_req(OP_POP_FRONT, 32'sd6, 6'd0));
      send_gapped(make_req(OP_READ, 32'sd0, 6'd0));
      send_gapped(make_req(OP_PUSH_BACK, 32'sh7fff_ffff, 6'd63));
      send_gapped(make_req(OP_PUSH_BACK, 32'sh8000_0000, 6'd0));
      send_gapped(make_req(OP_PUSH_FRONT, 32'sd0, 6'd21));
      send_gapped(make_req(OP_PUSH_FRONT, -32'sd1, 6'd42));
      send_gapped(make_req(OP_READ, 32'sd0, 6'd0));
      send_gapped(make_req(OP_READ, -32'sd1, 6'd3));
      send_gapped(make_req(OP_READ, 32'sd0, 6'd4));
      send_gapped(make_req(OP_READ, 32'sd0, 6'd63));
      send_gapped(make_req(OP_NOP_SIX, 32'sh1234_5678, 6'd1));
      send_gapped(make_req(OP_NOP_SEVEN, -32'sd1, 6'd63));
      send_gapped(make_req(OP_POP_BACK, 32'sd0, 6'd0));
      send_gapped(make_req(OP_POP_FRONT, 32'sd0, 6'd0));
      send_gapped(make_req(OP_READ, 32'sd0, 6'd1));
      send_gapped(make_req(OP_CLEAR, 32'sd9, 6'd7));
      send_gapped(make_req(OP_POP_BACK, 32'sd0, 6'd0));
      send_gapped(make_req(OP_PUSH_FRONT, 32'sh5a5a_5a5a, 6'd63));
      send_gapped(make_req(OP_POP_FRONT, 32'sd0, 6'd0));
   endtask

   // fill to capacity, push into the full deque, then drain from both ends
   task automatic test_fill_and_drain();
      while (deque_len < DEQUE_DEPTH)
         send_gapped(make_req($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                              rand_word(), POS_W'($urandom_range(0, 63))));
      send_gapped(make_req(OP_PUSH_BACK, rand_word(), 6'd0));
      send_gapped(make_req(OP_PUSH_FRONT, rand_word(), 6'd0));
      send_gapped(make_req(OP_READ, 32'sd0, 6'd63));
      send_gapped(make_req(OP_READ, 32'sd0, 6'd0));
      while (deque_len != 0)
         send_gapped(make_req($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT,
                              rand_word(), POS_W'($urandom_range(0, 63))));
      send_gapped(make_req(OP_POP_FRONT, 32'sd0, 6'd0));
   endtask

   // sender waits for every outstanding response before carrying on
   task automatic test_pause_for_drain();
      send_random(20, 60);
      hold_sender(1);
      wait_for_drain();
      send_random(10, 40);
   endtask

   // growing, balanced and shrinking mixes
   task automatic test_random_mix();
      send_random(150, 60);
      send_random(150, 40);
      send_random(150, 25);
   endtask

   // beats with no sender gaps and no receiver stalls
   task automatic test_calm_tail();
      calm_phase <= 1'b1;
      send_random(150, 45);
   endtask

   // receiver stalls in random bursts
   always @(posedge clock) begin
      if (reset || calm_phase) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(0, 12);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // response check and cycle limit
   always @(posedge clock) begin
      bdq_rsp_type want;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("[bounded_deque_engine_unit] ERROR");
            $finish;
         end else if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("response beat with nothing expected");
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.data !== want.data)
                  report_mismatch($sformatf("data %0d, expected %0d",
                                            rsp_data.data, want.data));
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.count !== want.count)
                  report_mismatch($sformatf("count %0d, expected %0d",
                                            rsp_data.count, want.count));
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_edge_cases();
      test_fill_and_drain();
      test_pause_for_drain();
      test_random_mix();
      test_calm_tail();
      hold_sender(1);
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[bounded_deque_engine_unit] OK");
      else
         $display("[bounded_deque_engine_unit] ERROR");
      $finish;
   end

endmodule
